// ===== src/bclm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclm_pkg
// Shared widths, codes, defaults and types of the cell limit monitor.
// ----------------------------------------------------------------------------
package bclm_pkg;

    localparam int FUNC_W     = 3;
    localparam int SEGF_W     = 8;
    localparam int VOLT_W     = 16;
    localparam int TEMP_W     = 16;
    localparam int SUM_W      = 24;
    localparam int MODE_W     = 2;
    localparam int TAPS_W     = 5;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int TAP_CW     = 5;
    localparam int CNT_W      = 3;
    localparam int DIFF_W     = VOLT_W + 1;
    localparam int ALU_W      = 26;
    localparam int GROUP_CELLS = 6;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam int DEF_SEGMENTS          = 8;
    localparam int DEF_TEMPS_PER_SEGMENT = 8;
    localparam int DEF_MAX_TAPS          = 18;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CELL_V   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CELL_V   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHG_TEMP_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHG_TEMP_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIS_TEMP_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIS_TEMP_MIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PACK_MODE    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS         = 3'd7;

    // message function codes
    localparam logic [FUNC_W-1:0] FUNC_LAST_CELL = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_TEMP      = 3'd3;

    // pack modes
    localparam logic [MODE_W-1:0] MODE_DISCHARGE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHARGE    = 2'd1;

    // shared unit operations
    localparam logic [1:0] ALU_ADD   = 2'd0;
    localparam logic [1:0] ALU_SUB   = 2'd1;
    localparam logic [1:0] ALU_ACC   = 2'd2;
    localparam logic [1:0] ALU_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [ALU_W-1:0] a;
        logic signed [ALU_W-1:0] b;
        logic signed [ALU_W-1:0] c;
        logic signed [ALU_W-1:0] d;
    } alu_req_t;

    typedef struct packed {
        logic signed [ALU_W-1:0] res;
        logic                    out_of_range;
    } alu_rsp_t;

endpackage

// ===== src/bclm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclm_if
// Request and status channels of the cell limit monitor.
// ----------------------------------------------------------------------------
interface bclm_in_if
    import bclm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [SEGF_W-1:0]        segment;
    logic [VOLT_W-1:0]        cell_voltage_0;
    logic [VOLT_W-1:0]        cell_voltage_1;
    logic [VOLT_W-1:0]        cell_voltage_2;
    logic [VOLT_W-1:0]        cell_voltage_3;
    logic [VOLT_W-1:0]        cell_voltage_4;
    logic [VOLT_W-1:0]        cell_voltage_5;
    logic signed [TEMP_W-1:0] seg_max_temp;
    logic signed [TEMP_W-1:0] seg_min_temp;
    logic signed [TEMP_W-1:0] seg_avg_temp;

    modport source
    (
        output valid, func, segment,
        output cell_voltage_0, cell_voltage_1, cell_voltage_2,
        output cell_voltage_3, cell_voltage_4, cell_voltage_5,
        output seg_max_temp, seg_min_temp, seg_avg_temp,
        input  ready
    );

    modport sink
    (
        input  valid, func, segment,
        input  cell_voltage_0, cell_voltage_1, cell_voltage_2,
        input  cell_voltage_3, cell_voltage_4, cell_voltage_5,
        input  seg_max_temp, seg_min_temp, seg_avg_temp,
        output ready
    );
endinterface

interface bclm_out_if
    import bclm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             fault;
    logic             sdc_ok;
    logic [SUM_W-1:0] pack_voltage_sum;

    modport source
    (
        output valid, fault, sdc_ok, pack_voltage_sum,
        input  ready
    );

    modport sink
    (
        input  valid, fault, sdc_ok, pack_voltage_sum,
        output ready
    );
endinterface

// ===== src/bclm_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclm_alu
// Shared add, subtract, saturating accumulate and range compare unit.
// ----------------------------------------------------------------------------
module bclm_alu
    import bclm_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic signed [ALU_W-1:0] sum;

    assign sum = req.a + req.b;

    always_comb
    begin
        rsp.out_of_range = (req.a < req.b) || (req.c > req.d);
        unique case (req.op)
            ALU_ADD:
            begin
                rsp.res = sum;
            end
            ALU_SUB:
            begin
                rsp.res = req.a - req.b;
            end
            ALU_ACC:
            begin
                rsp.res = (sum > ALU_W'(SUM_MAX)) ? ALU_W'(SUM_MAX) : sum;
            end
            default:
            begin
                rsp.res = '0;
            end
        endcase
    end

endmodule

// ===== src/bclm_cell_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclm_cell_store
// Cell voltage memory, one address shared by a write port and a registered read
// port, with a written flag per entry so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module bclm_cell_store
    import bclm_pkg::*;
#(
    parameter int DEPTH  = DEF_SEGMENTS * DEF_MAX_TAPS,
    parameter int ADDR_W = $clog2(DEF_SEGMENTS * DEF_MAX_TAPS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [VOLT_W-1:0] wr_data,
    output logic [VOLT_W-1:0] rd_data
);

    logic [VOLT_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  written_reg;
    logic [VOLT_W-1:0] rd_mem_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_mem_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= written_reg[addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : '0;

endmodule

// ===== src/bclm_temp_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclm_temp_store
// Thermistor slot memory, filled one slot per cycle.
// ----------------------------------------------------------------------------
module bclm_temp_store
    import bclm_pkg::*;
#(
    parameter int DEPTH  = DEF_SEGMENTS * DEF_TEMPS_PER_SEGMENT,
    parameter int ADDR_W = $clog2(DEF_SEGMENTS * DEF_TEMPS_PER_SEGMENT)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [TEMP_W-1:0] wr_data
);

    logic [TEMP_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

endmodule

// ===== src/battery_cell_limit_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_cell_limit_monitor
// Range checks cell voltage and temperature messages, latches the fault and
// reports the pack voltage sum after each message.
//
//   channel  dir   payload
//   msg      in    func, segment, cell_voltage_0..5, seg_max/min/avg_temp
//   status   out   fault, sdc_ok, pack_voltage_sum
//   cfg_*    in    cfg_we, cfg_index, cfg_data
//
// Each message is handled in turn: a cell message checks, stores and adds each
// cell of its group until a check fails or the taps in use run out, a
// temperature message that passes writes its average to every slot of the
// segment, and then the column sums of the taps in use are added up. The shared
// arithmetic unit and the single port of the cell memory serialise this walk.
// Reset clears the fault and the column sums and sets the configuration to its defaults.
// A waiting status result holds the next message only in the final state, S_DONE.
// ----------------------------------------------------------------------------
module battery_cell_limit_monitor
    import bclm_pkg::*;
#(
    parameter int SEGMENTS          = DEF_SEGMENTS,
    parameter int TEMPS_PER_SEGMENT = DEF_TEMPS_PER_SEGMENT,
    parameter int MAX_TAPS          = DEF_MAX_TAPS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    bclm_in_if.sink              msg,
    bclm_out_if.source           status,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int SEG_W   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int TAP_W   = $clog2(MAX_TAPS);
    localparam int CDEPTH  = SEGMENTS * MAX_TAPS;
    localparam int CADDR_W = $clog2(CDEPTH);
    localparam int TDEPTH  = SEGMENTS * TEMPS_PER_SEGMENT;
    localparam int TADDR_W = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int TI_W    = (TEMPS_PER_SEGMENT > 1) ? $clog2(TEMPS_PER_SEGMENT) : 1;
    localparam int COL_W   = $clog2(SEGMENTS * 65535 + 1);

    localparam logic [SEGF_W-1:0] SEG_LIM  = SEGF_W'(SEGMENTS);
    localparam logic [TAPS_W-1:0] TAPS_LIM = TAPS_W'(MAX_TAPS);
    localparam logic [TI_W-1:0]   TI_LAST  = TI_W'(TEMPS_PER_SEGMENT - 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CELL_CHK = 4'd1;
    localparam logic [3:0] S_CELL_SUB = 4'd2;
    localparam logic [3:0] S_CELL_ADD = 4'd3;
    localparam logic [3:0] S_TEMP_CHK = 4'd4;
    localparam logic [3:0] S_TEMP_WR  = 4'd5;
    localparam logic [3:0] S_SUM_INIT = 4'd6;
    localparam logic [3:0] S_SUM      = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    // configuration
    logic [VOLT_W-1:0]        min_v_reg;
    logic [VOLT_W-1:0]        max_v_reg;
    logic signed [TEMP_W-1:0] chg_max_reg;
    logic signed [TEMP_W-1:0] chg_min_reg;
    logic signed [TEMP_W-1:0] dis_max_reg;
    logic signed [TEMP_W-1:0] dis_min_reg;
    logic [MODE_W-1:0]        mode_reg;
    logic [TAPS_W-1:0]        taps_reg;

    // sequencer
    logic [3:0]               state_reg, state_next;
    logic [SEG_W-1:0]         seg_reg, seg_next;
    logic [VOLT_W-1:0]        cell_reg [GROUP_CELLS];
    logic signed [TEMP_W-1:0] tmax_reg, tmin_reg, tavg_reg;
    logic [TAP_CW-1:0]        tap_reg, tap_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [TI_W-1:0]          tcnt_reg, tcnt_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic [SUM_W-1:0]         acc_reg, acc_next;
    logic                     fault_reg, fault_next;
    logic [COL_W-1:0]         col_reg [MAX_TAPS];
    logic                     col_we;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_fault_reg;
    logic [SUM_W-1:0]         out_sum_reg;
    logic                     out_load;

    logic                     accept;
    logic [TAPS_W-1:0]        limit;
    logic [TAP_W-1:0]         col_idx;
    logic [COL_W-1:0]         col_rd;
    logic [VOLT_W-1:0]        cur_v;
    logic                     temp_check_on;

    alu_req_t                 alu_req;
    alu_rsp_t                 alu_rsp;

    logic                     cmem_rd, cmem_wr;
    logic [CADDR_W-1:0]       cmem_addr;
    logic [VOLT_W-1:0]        cmem_rd_data;
    logic                     tmem_wr;
    logic [TADDR_W-1:0]       tmem_addr;

    assign accept        = msg.valid && msg.ready;
    assign msg.ready     = (state_reg == S_IDLE);
    assign limit         = (taps_reg > TAPS_LIM) ? TAPS_LIM : taps_reg;
    assign col_idx       = tap_reg[TAP_W-1:0];
    assign col_rd        = col_reg[col_idx];
    assign cur_v         = cell_reg[cnt_reg];
    assign temp_check_on = (mode_reg == MODE_DISCHARGE) || (mode_reg == MODE_CHARGE);
    assign cmem_addr     = CADDR_W'(seg_reg) * CADDR_W'(MAX_TAPS) + CADDR_W'(tap_reg);
    assign tmem_addr     = TADDR_W'(seg_reg) * TADDR_W'(TEMPS_PER_SEGMENT)
                         + TADDR_W'(tcnt_reg);
    assign tmem_wr       = (state_reg == S_TEMP_WR);
    assign out_load      = (state_reg == S_DONE) && (!out_valid_reg || status.ready);

    assign status.valid            = out_valid_reg;
    assign status.fault            = out_fault_reg;
    assign status.sdc_ok           = !out_fault_reg;
    assign status.pack_voltage_sum = out_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_v_reg   <= '0;
            max_v_reg   <= '1;
            chg_max_reg <= 16'sh7fff;
            chg_min_reg <= 16'sh8000;
            dis_max_reg <= 16'sh7fff;
            dis_min_reg <= 16'sh8000;
            mode_reg    <= MODE_DISCHARGE;
            taps_reg    <= TAPS_W'(18);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_CELL_V:   min_v_reg   <= cfg_data;
                REG_MAX_CELL_V:   max_v_reg   <= cfg_data;
                REG_CHG_TEMP_MAX: chg_max_reg <= cfg_data;
                REG_CHG_TEMP_MIN: chg_min_reg <= cfg_data;
                REG_DIS_TEMP_MAX: dis_max_reg <= cfg_data;
                REG_DIS_TEMP_MIN: dis_min_reg <= cfg_data;
                REG_PACK_MODE:    mode_reg    <= cfg_data[MODE_W-1:0];
                REG_TAPS:         taps_reg    <= cfg_data[TAPS_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        alu_req = '0;
        alu_req.op = ALU_ADD;
        unique case (state_reg)
            S_CELL_CHK:
            begin
                alu_req.op = ALU_RANGE;
                alu_req.a  = ALU_W'(cur_v);
                alu_req.b  = ALU_W'(min_v_reg);
                alu_req.c  = ALU_W'(cur_v);
                alu_req.d  = ALU_W'(max_v_reg);
            end
            S_CELL_SUB:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = ALU_W'(cur_v);
                alu_req.b  = ALU_W'(cmem_rd_data);
            end
            S_CELL_ADD:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = ALU_W'(col_rd);
                alu_req.b  = ALU_W'(diff_reg);
            end
            S_TEMP_CHK:
            begin
                alu_req.op = ALU_RANGE;
                alu_req.a  = ALU_W'(tmin_reg);
                alu_req.c  = ALU_W'(tmax_reg);
                alu_req.b  = (mode_reg == MODE_CHARGE) ? ALU_W'(chg_min_reg)
                                                       : ALU_W'(dis_min_reg);
                alu_req.d  = (mode_reg == MODE_CHARGE) ? ALU_W'(chg_max_reg)
                                                       : ALU_W'(dis_max_reg);
            end
            S_SUM:
            begin
                alu_req.op = ALU_ACC;
                alu_req.a  = ALU_W'(acc_reg);
                alu_req.b  = ALU_W'(col_rd);
            end
            default:
            begin
                alu_req.op = ALU_ADD;
            end
        endcase
    end

    bclm_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        seg_next       = seg_reg;
        tap_next       = tap_reg;
        cnt_next       = cnt_reg;
        tcnt_next      = tcnt_reg;
        diff_next      = diff_reg;
        acc_next       = acc_reg;
        fault_next     = fault_reg;
        out_valid_next = out_valid_reg;
        cmem_rd        = 1'b0;
        cmem_wr        = 1'b0;
        col_we         = 1'b0;

        if (status.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    seg_next = msg.segment[SEG_W-1:0];
                    cnt_next = '0;
                    tap_next = TAP_CW'(msg.func) * TAP_CW'(GROUP_CELLS);
                    priority if (msg.segment >= SEG_LIM || msg.func > FUNC_TEMP)
                    begin
                        state_next = S_SUM_INIT;
                    end
                    else if (msg.func == FUNC_TEMP)
                    begin
                        state_next = S_TEMP_CHK;
                    end
                    else
                    begin
                        state_next = S_CELL_CHK;
                    end
                end
            end
            S_CELL_CHK:
            begin
                priority if (tap_reg >= TAP_CW'(limit))
                begin
                    state_next = S_SUM_INIT;
                end
                else if (alu_rsp.out_of_range)
                begin
                    fault_next = 1'b1;
                    state_next = S_SUM_INIT;
                end
                else
                begin
                    cmem_rd    = 1'b1;
                    state_next = S_CELL_SUB;
                end
            end
            S_CELL_SUB:
            begin
                cmem_wr    = 1'b1;
                diff_next  = alu_rsp.res[DIFF_W-1:0];
                state_next = S_CELL_ADD;
            end
            S_CELL_ADD:
            begin
                col_we = 1'b1;
                if (cnt_reg == CNT_W'(GROUP_CELLS - 1))
                begin
                    state_next = S_SUM_INIT;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    tap_next   = tap_reg + 1'b1;
                    state_next = S_CELL_CHK;
                end
            end
            S_TEMP_CHK:
            begin
                tcnt_next = '0;
                if (temp_check_on && alu_rsp.out_of_range)
                begin
                    fault_next = 1'b1;
                    state_next = S_SUM_INIT;
                end
                else
                begin
                    state_next = S_TEMP_WR;
                end
            end
            S_TEMP_WR:
            begin
                if (tcnt_reg == TI_LAST)
                begin
                    state_next = S_SUM_INIT;
                end
                else
                begin
                    tcnt_next = tcnt_reg + 1'b1;
                end
            end
            S_SUM_INIT:
            begin
                acc_next   = '0;
                tap_next   = '0;
                state_next = (limit == '0) ? S_DONE : S_SUM;
            end
            S_SUM:
            begin
                acc_next = alu_rsp.res[SUM_W-1:0];
                if (TAPS_W'(tap_reg) == limit - 1'b1)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tap_reg       <= '0;
            cnt_reg       <= '0;
            tcnt_reg      <= '0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                col_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            cnt_reg       <= cnt_next;
            tcnt_reg      <= tcnt_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
            if (col_we)
            begin
                col_reg[col_idx] <= alu_rsp.res[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg  <= seg_next;
        diff_reg <= diff_next;
        acc_reg  <= acc_next;
        if (accept)
        begin
            cell_reg[0] <= msg.cell_voltage_0;
            cell_reg[1] <= msg.cell_voltage_1;
            cell_reg[2] <= msg.cell_voltage_2;
            cell_reg[3] <= msg.cell_voltage_3;
            cell_reg[4] <= msg.cell_voltage_4;
            cell_reg[5] <= msg.cell_voltage_5;
            tmax_reg    <= msg.seg_max_temp;
            tmin_reg    <= msg.seg_min_temp;
            tavg_reg    <= msg.seg_avg_temp;
        end
        if (out_load)
        begin
            out_fault_reg <= fault_reg;
            out_sum_reg   <= acc_reg;
        end
    end

    bclm_cell_store #(
        .DEPTH  (CDEPTH),
        .ADDR_W (CADDR_W)
    ) u_cell_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (cmem_rd),
        .wr_en   (cmem_wr),
        .addr    (cmem_addr),
        .wr_data (cur_v),
        .rd_data (cmem_rd_data)
    );

    bclm_temp_store #(
        .DEPTH  (TDEPTH),
        .ADDR_W (TADDR_W)
    ) u_temp_store
    (
        .clk     (clk),
        .wr_en   (tmem_wr),
        .addr    (tmem_addr),
        .wr_data (tavg_reg)
    );

`ifndef SYNTHESIS
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(fault_reg))
        else $error("latched fault cleared");

    a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !msg.ready)
        else $error("request taken while busy");

    a_sum_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |-> (TAPS_W'(tap_reg) < limit))
        else $error("sum walks past taps in use");

    a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not presented");
`endif

endmodule

// ===== tb/sv/battery_cell_limit_monitor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_cell_limit_monitor_tb
// Self-checking bench for the cell limit monitor. Directed requests cover
// group and tap boundaries, voltage limits, temperature limits in each pack
// mode and ignored requests. Random requests then run under three idling
// profiles, with the latched fault driven between the first two. Every status
// is checked against a predictor that tracks the cells, config and fault.
// ----------------------------------------------------------------------------
module battery_cell_limit_monitor_tb;
    import bclm_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_GROUP0 = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_GROUP1 = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_OTHER  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_TOP    = 3'd7;
    localparam logic [MODE_W-1:0] MODE_NO_CHECK = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;
    localparam logic [TAPS_W-1:0] TAPS_TOP      = {TAPS_W{1'b1}};
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 64;
    localparam int BLOCK_ITEMS   = 100;

    typedef struct packed {
        logic [FUNC_W-1:0]                  func;
        logic [SEGF_W-1:0]                  segment;
        logic [GROUP_CELLS-1:0][VOLT_W-1:0] cells;
        logic signed [TEMP_W-1:0]           max_temp;
        logic signed [TEMP_W-1:0]           min_temp;
        logic signed [TEMP_W-1:0]           avg_temp;
    } msg_t;

    typedef struct packed {
        logic             fault;
        logic             sdc_ok;
        logic [SUM_W-1:0] pack_voltage_sum;
    } status_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    bclm_in_if  msg_if ();
    bclm_out_if status_if ();

    battery_cell_limit_monitor dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg_if),
        .status    (status_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [VOLT_W-1:0]        cell_store [DEF_SEGMENTS][DEF_MAX_TAPS];
    logic                     fault_seen;
    logic [VOLT_W-1:0]        cell_min;
    logic [VOLT_W-1:0]        cell_max;
    logic signed [TEMP_W-1:0] chg_tmax;
    logic signed [TEMP_W-1:0] chg_tmin;
    logic signed [TEMP_W-1:0] dis_tmax;
    logic signed [TEMP_W-1:0] dis_tmin;
    logic [MODE_W-1:0]        pack_mode_q;
    logic [TAPS_W-1:0]        taps_q;

    status_t expected_status [$];
    int      error_count   = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic status_t predict_status(input msg_t m);
        status_t     s;
        logic [31:0] acc;
        int          lim;
        int          tap;
        bit          stop;
        bit          bad;
        lim  = (taps_q > DEF_MAX_TAPS) ? DEF_MAX_TAPS : int'(taps_q);
        stop = 1'b0;
        bad  = 1'b0;
        if (m.segment < DEF_SEGMENTS)
        begin
            if (m.func <= FUNC_LAST_CELL)
            begin
                for (int i = 0; i < GROUP_CELLS && !stop; i++)
                begin
                    tap = int'(m.func) * GROUP_CELLS + i;
                    if (tap < lim)
                    begin
                        if (m.cells[i] < cell_min || m.cells[i] > cell_max)
                        begin
                            fault_seen = 1'b1;
                            stop       = 1'b1;
                        end
                        else
                        begin
                            cell_store[m.segment][tap] = m.cells[i];
                        end
                    end
                end
            end
            else if (m.func == FUNC_TEMP)
            begin
                if (pack_mode_q == MODE_CHARGE)
                    bad = (m.max_temp > chg_tmax) || (m.min_temp < chg_tmin);
                else if (pack_mode_q == MODE_DISCHARGE)
                    bad = (m.max_temp > dis_tmax) || (m.min_temp < dis_tmin);
                if (bad)
                    fault_seen = 1'b1;
            end
        end
        acc = '0;
        for (int sg = 0; sg < DEF_SEGMENTS; sg++)
        begin
            for (int t = 0; t < lim; t++)
            begin
                acc = acc + cell_store[sg][t];
                if (acc > SUM_MAX)
                    acc = 32'(SUM_MAX);
            end
        end
        s.fault            = fault_seen;
        s.sdc_ok           = !fault_seen;
        s.pack_voltage_sum = acc[SUM_W-1:0];
        return s;
    endfunction

    function automatic msg_t blank_msg(input logic [FUNC_W-1:0] func,
                                       input logic [SEGF_W-1:0] segment,
                                       input logic [VOLT_W-1:0] fill);
        msg_t m;
        m.func     = func;
        m.segment  = segment;
        for (int i = 0; i < GROUP_CELLS; i++)
            m.cells[i] = fill;
        m.max_temp = '0;
        m.min_temp = '0;
        m.avg_temp = '0;
        return m;
    endfunction

    function automatic logic [VOLT_W-1:0] cell_value();
        if (cell_min > cell_max || $urandom_range(24) == 0)
            return VOLT_W'($urandom);
        return VOLT_W'($urandom_range(cell_max, cell_min));
    endfunction

    function automatic msg_t random_msg();
        msg_t m;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 60)
            m.func = FUNC_W'($urandom_range(FUNC_LAST_CELL, FUNC_GROUP0));
        else if (pick < 80)
            m.func = FUNC_TEMP;
        else
            m.func = FUNC_W'($urandom_range(FUNC_TOP, FUNC_GROUP0));
        if (pick < 80)
            m.segment = SEGF_W'($urandom_range(DEF_SEGMENTS - 1, 0));
        else
            m.segment = SEGF_W'($urandom);
        for (int i = 0; i < GROUP_CELLS; i++)
            m.cells[i] = cell_value();
        m.max_temp = TEMP_W'($urandom);
        m.min_temp = TEMP_W'($urandom);
        m.avg_temp = TEMP_W'($urandom);
        return m;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_MIN_CELL_V:   cell_min    = data;
            REG_MAX_CELL_V:   cell_max    = data;
            REG_CHG_TEMP_MAX: chg_tmax    = data;
            REG_CHG_TEMP_MIN: chg_tmin    = data;
            REG_DIS_TEMP_MAX: dis_tmax    = data;
            REG_DIS_TEMP_MIN: dis_tmin    = data;
            REG_PACK_MODE:    pack_mode_q = data[MODE_W-1:0];
            REG_TAPS:         taps_q      = data[TAPS_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_msg(input msg_t m);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            msg_if.valid <= 1'b0;
            @(negedge clk);
        end
        msg_if.valid          <= 1'b1;
        msg_if.func           <= m.func;
        msg_if.segment        <= m.segment;
        msg_if.cell_voltage_0 <= m.cells[0];
        msg_if.cell_voltage_1 <= m.cells[1];
        msg_if.cell_voltage_2 <= m.cells[2];
        msg_if.cell_voltage_3 <= m.cells[3];
        msg_if.cell_voltage_4 <= m.cells[4];
        msg_if.cell_voltage_5 <= m.cells[5];
        msg_if.seg_max_temp   <= m.max_temp;
        msg_if.seg_min_temp   <= m.min_temp;
        msg_if.seg_avg_temp   <= m.avg_temp;
        @(posedge clk);
        while (!msg_if.ready)
            @(posedge clk);
        expected_status.push_back(predict_status(m));
    endtask

    // hold requests until every status is back, then let the block settle
    task automatic wait_idle(input int settle);
        @(negedge clk);
        msg_if.valid <= 1'b0;
        while (expected_status.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic set_limits(input bit wide);
        logic [TAPS_W-1:0] taps;
        case ($urandom_range(5))
            0:       taps = '0;
            1:       taps = TAPS_W'(DEF_MAX_TAPS);
            2:       taps = TAPS_TOP;
            default: taps = TAPS_W'($urandom_range(TAPS_TOP, 0));
        endcase
        wait_idle(SETTLE_CYCLES);
        if (wide)
        begin
            write_reg(REG_MIN_CELL_V, '0);
            write_reg(REG_MAX_CELL_V, '1);
            write_reg(REG_CHG_TEMP_MAX, 16'h7FFF);
            write_reg(REG_CHG_TEMP_MIN, 16'h8000);
            write_reg(REG_DIS_TEMP_MAX, 16'h7FFF);
            write_reg(REG_DIS_TEMP_MIN, 16'h8000);
        end
        else
        begin
            write_reg(REG_MIN_CELL_V, CFG_W'($urandom_range(16'h4000, 0)));
            write_reg(REG_MAX_CELL_V, CFG_W'($urandom_range(16'hFFFF, 16'hC000)));
            write_reg(REG_CHG_TEMP_MAX, CFG_W'($urandom));
            write_reg(REG_CHG_TEMP_MIN, CFG_W'($urandom));
            write_reg(REG_DIS_TEMP_MAX, CFG_W'($urandom));
            write_reg(REG_DIS_TEMP_MIN, CFG_W'($urandom));
        end
        write_reg(REG_PACK_MODE, CFG_W'($urandom_range(MODE_SPARE, MODE_DISCHARGE)));
        write_reg(REG_TAPS, CFG_W'(taps));
    endtask

    task automatic test_reset_state();
        send_msg(blank_msg(FUNC_OTHER, 8'd0, 16'h0000));
    endtask

    task automatic test_cell_groups();
        msg_t m;
        send_msg(blank_msg(FUNC_GROUP0, 8'd0, 16'hFFFF));
        send_msg(blank_msg(FUNC_GROUP1, 8'd0, 16'hFFFF));
        send_msg(blank_msg(FUNC_LAST_CELL, 8'd0, 16'hFFFF));
        m = blank_msg(FUNC_GROUP1, SEGF_W'(DEF_SEGMENTS - 1), 16'hAAAA);
        m.cells[1] = 16'h5555;
        m.cells[3] = 16'h5555;
        m.cells[5] = 16'h5555;
        send_msg(m);
    endtask

    task automatic test_tap_counts();
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_TAPS, 16'd7);
        send_msg(blank_msg(FUNC_GROUP1, 8'd3, 16'h1234));
        send_msg(blank_msg(FUNC_LAST_CELL, 8'd3, 16'h4321));
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_TAPS, 16'd0);
        send_msg(blank_msg(FUNC_GROUP0, 8'd4, 16'h7777));
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_TAPS, CFG_W'(TAPS_TOP));
        send_msg(blank_msg(FUNC_LAST_CELL, 8'd4, 16'h0101));
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_TAPS, 16'd13);
        send_msg(blank_msg(FUNC_LAST_CELL, 8'd5, 16'h0F0F));
    endtask

    task automatic test_cell_limit_edges();
        msg_t m;
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_TAPS, CFG_W'(DEF_MAX_TAPS));
        write_reg(REG_MIN_CELL_V, 16'h1000);
        write_reg(REG_MAX_CELL_V, 16'hF000);
        m = blank_msg(FUNC_GROUP0, 8'd1, 16'h1000);
        m.cells[1] = 16'hF000;
        m.cells[3] = 16'hF000;
        m.cells[5] = 16'hF000;
        send_msg(m);
    endtask

    // limits of the inactive mode would fail each of these requests
    task automatic test_temp_modes();
        msg_t m;
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_CHG_TEMP_MAX, 16'd100);
        write_reg(REG_CHG_TEMP_MIN, CFG_W'(-100));
        write_reg(REG_DIS_TEMP_MAX, 16'd50);
        write_reg(REG_DIS_TEMP_MIN, CFG_W'(-2000));
        write_reg(REG_PACK_MODE, CFG_W'(MODE_DISCHARGE));
        m = blank_msg(FUNC_TEMP, 8'd2, 16'h2000);
        m.max_temp = 16'sd50;
        m.min_temp = -16'sd2000;
        m.avg_temp = -16'sd7;
        send_msg(m);
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_PACK_MODE, CFG_W'(MODE_CHARGE));
        m.max_temp = 16'sd100;
        m.min_temp = -16'sd100;
        send_msg(m);
        m.max_temp = 16'sh7FFF;
        m.min_temp = 16'sh8000;
        m.avg_temp = 16'sh8000;
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_PACK_MODE, CFG_W'(MODE_NO_CHECK));
        send_msg(m);
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_PACK_MODE, CFG_W'(MODE_SPARE));
        m.avg_temp = 16'sh7FFF;
        send_msg(m);
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_PACK_MODE, CFG_W'(MODE_DISCHARGE));
    endtask

    // each of these would latch the fault if it were processed
    task automatic test_ignored();
        msg_t m;
        send_msg(blank_msg(FUNC_GROUP0, SEGF_W'(DEF_SEGMENTS), 16'h0000));
        m = blank_msg(FUNC_TEMP, 8'hFF, 16'h0000);
        m.max_temp = 16'sh7FFF;
        send_msg(m);
        send_msg(blank_msg(FUNC_OTHER, 8'd0, 16'h0000));
        m.func    = FUNC_TOP;
        m.segment = 8'd7;
        send_msg(m);
    endtask

    task automatic test_fault_latch();
        msg_t m;
        int   kind;
        kind = $urandom_range(5);
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_MIN_CELL_V, 16'h2000);
        write_reg(REG_MAX_CELL_V, 16'hE000);
        write_reg(REG_CHG_TEMP_MAX, 16'd1000);
        write_reg(REG_CHG_TEMP_MIN, CFG_W'(-1000));
        write_reg(REG_DIS_TEMP_MAX, 16'd1000);
        write_reg(REG_DIS_TEMP_MIN, CFG_W'(-1000));
        write_reg(REG_TAPS, CFG_W'(DEF_MAX_TAPS));
        write_reg(REG_PACK_MODE, CFG_W'((kind < 4) ? MODE_CHARGE : MODE_DISCHARGE));
        if (kind < 2)
        begin
            // stop part way: the first cells stay stored
            m = blank_msg(FUNC_GROUP1, 8'd2, 16'h3000);
            m.cells[2] = (kind == 0) ? 16'h1FFF : 16'hE001;
            m.cells[3] = 16'h5000;
        end
        else
        begin
            m = blank_msg(FUNC_TEMP, 8'd2, 16'h3000);
            m.max_temp = (kind % 2 == 0) ? 16'sd1001 : 16'sd1000;
            m.min_temp = (kind % 2 == 0) ? -16'sd1000 : -16'sd1001;
        end
        send_msg(m);
        send_msg(blank_msg(FUNC_GROUP0, 8'd5, 16'h4444));
        send_msg(blank_msg(FUNC_LAST_CELL, 8'd6, 16'hFFFF));
    endtask

    task automatic run_random(input int send_pct, input int recv_pct, input bit wide);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int b = 0; b < 4; b++)
        begin
            set_limits(wide);
            repeat (BLOCK_ITEMS) send_msg(random_msg());
        end
    endtask

    always @(negedge clk)
        status_if.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : check_status
        status_t want;
        if (rst_n && status_if.valid && status_if.ready)
        begin
            if (expected_status.size() == 0)
            begin
                $display("%0t status with nothing expected: fault %0b sdc_ok %0b sum %0d",
                         $time, status_if.fault, status_if.sdc_ok,
                         status_if.pack_voltage_sum);
                error_count++;
            end
            else
            begin
                want = expected_status.pop_front();
                if (status_if.fault !== want.fault)
                begin
                    $display("%0t fault: expected %0b, actual %0b",
                             $time, want.fault, status_if.fault);
                    error_count++;
                end
                if (status_if.sdc_ok !== want.sdc_ok)
                begin
                    $display("%0t sdc_ok: expected %0b, actual %0b",
                             $time, want.sdc_ok, status_if.sdc_ok);
                    error_count++;
                end
                if (status_if.pack_voltage_sum !== want.pack_voltage_sum)
                begin
                    $display("%0t pack_voltage_sum: expected %0d, actual %0d",
                             $time, want.pack_voltage_sum, status_if.pack_voltage_sum);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #(4_000_000);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        msg_if.valid          = 1'b0;
        msg_if.func           = '0;
        msg_if.segment        = '0;
        msg_if.cell_voltage_0 = '0;
        msg_if.cell_voltage_1 = '0;
        msg_if.cell_voltage_2 = '0;
        msg_if.cell_voltage_3 = '0;
        msg_if.cell_voltage_4 = '0;
        msg_if.cell_voltage_5 = '0;
        msg_if.seg_max_temp   = '0;
        msg_if.seg_min_temp   = '0;
        msg_if.seg_avg_temp   = '0;
        fault_seen  = 1'b0;
        cell_min    = '0;
        cell_max    = '1;
        chg_tmax    = 16'sh7FFF;
        chg_tmin    = 16'sh8000;
        dis_tmax    = 16'sh7FFF;
        dis_tmin    = 16'sh8000;
        pack_mode_q = MODE_DISCHARGE;
        taps_q      = TAPS_W'(DEF_MAX_TAPS);
        for (int sg = 0; sg < DEF_SEGMENTS; sg++)
            for (int t = 0; t < DEF_MAX_TAPS; t++)
                cell_store[sg][t] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 16;
        recv_idle_pct = 83;
        test_reset_state();
        test_cell_groups();
        test_tap_counts();
        test_cell_limit_edges();
        test_temp_modes();
        test_ignored();
        run_random(16, 83, 1'b1);
        test_fault_latch();
        run_random(83, 16, 1'b0);
        run_random(0, 0, 1'b0);

        wait_idle(DRAIN_CYCLES);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
